// File: hw/rtl/kvt_pkg.sv
// Package for the keyed value table: command codes, sequencer states and
// the result record that passes from the sequencer to the output stage.
// No dependencies.
`timescale 1ns / 1ps

package kvt_pkg;

  // Default number of table entries.
  localparam int unsigned ENTRIES_DEF = 16;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CMD_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET    = 2'd0,
    CMD_SET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic             full;
    logic [VAL_W-1:0] value;
    logic             hit;
  } result_t;

endpackage

// File: hw/rtl/keyed_value_table.sv
// Top level of the keyed value table: stream ports, key and value stores,
// scan sequencer and the output register. Depends on kvt_pkg, kvt_ram and
// kvt_seq.
`timescale 1ns / 1ps
//
//  Channel    Direction  Payload
//  s_axis     in         tuser: cmd[1:0]; tdata: key[31:0], value_in[63:32]
//  m_axis     out        tdata: hit[0], value_out[32:1], full_res[33], zero fill
//
// Each request is accepted and then scanned entry by entry (the single key
// comparator sits behind the registered read port of the key store); the
// last entry is compared in ST_LAST, and the commit happens in ST_RESP.
// A hit ends the scan early. While the output register
// is still held by the downstream side, the sequencer waits with its result
// and the input stays not ready; the table update is committed only when
// the result is loaded. Reset clears the valid marks at once; the key and
// value stores need no clearing.

module keyed_value_table #(
  parameter int unsigned ENTRIES = kvt_pkg::ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // key[31:0], value_in[63:32]
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // hit[0], value_out[32:1], full_res[33], zeros
);

  localparam int unsigned IdxW = $clog2(ENTRIES);

  logic [IdxW-1:0]           raddr;
  logic [IdxW-1:0]           waddr;
  logic                      key_we;
  logic                      val_we;
  logic [kvt_pkg::KEY_W-1:0] key_wdata;
  logic [kvt_pkg::VAL_W-1:0] val_wdata;
  logic [kvt_pkg::KEY_W-1:0] key_rdata;
  logic [kvt_pkg::VAL_W-1:0] val_rdata;

  logic             res_valid;
  logic             res_ready;
  kvt_pkg::result_t res;

  logic             out_valid_q;
  kvt_pkg::result_t out_q;

  // Key store and value store share the read address of the scan.
  kvt_ram #(
    .DEPTH(ENTRIES),
    .WIDTH(kvt_pkg::KEY_W)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(waddr),
    .wdata_i(key_wdata),
    .raddr_i(raddr),
    .rdata_o(key_rdata)
  );

  kvt_ram #(
    .DEPTH(ENTRIES),
    .WIDTH(kvt_pkg::VAL_W)
  ) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(waddr),
    .wdata_i(val_wdata),
    .raddr_i(raddr),
    .rdata_o(val_rdata)
  );

  kvt_seq #(
    .ENTRIES(ENTRIES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_cmd_i  (s_axis_tuser),
    .req_key_i  (s_axis_tdata[31:0]),
    .req_value_i(s_axis_tdata[63:32]),
    .raddr_o    (raddr),
    .key_rdata_i(key_rdata),
    .val_rdata_i(val_rdata),
    .waddr_o    (waddr),
    .key_we_o   (key_we),
    .val_we_o   (val_we),
    .key_wdata_o(key_wdata),
    .val_wdata_o(val_wdata),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // The output register takes a new result whenever it is empty or its
  // current result leaves in the same cycle, so the sequencer commits the
  // table update exactly when the result is loaded.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.full, out_q.value, out_q.hit};

endmodule

// File: hw/rtl/kvt_ram.sv
// Simple dual-port storage for the keyed value table: one write port and
// one read port with registered read data. No dependencies.
`timescale 1ns / 1ps

module kvt_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hw/rtl/kvt_seq.sv
// Scan sequencer of the keyed value table: walks the stores one entry per
// cycle through a single key comparator, keeps the valid marks and issues
// the table updates. Depends on kvt_pkg.
`timescale 1ns / 1ps

module kvt_seq #(
  parameter int unsigned ENTRIES = kvt_pkg::ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  logic [kvt_pkg::CMD_W-1:0]    req_cmd_i,
  input  logic [kvt_pkg::KEY_W-1:0]    req_key_i,
  input  logic [kvt_pkg::VAL_W-1:0]    req_value_i,
  output logic [$clog2(ENTRIES)-1:0]   raddr_o,
  input  logic [kvt_pkg::KEY_W-1:0]    key_rdata_i,
  input  logic [kvt_pkg::VAL_W-1:0]    val_rdata_i,
  output logic [$clog2(ENTRIES)-1:0]   waddr_o,
  output logic                         key_we_o,
  output logic                         val_we_o,
  output logic [kvt_pkg::KEY_W-1:0]    key_wdata_o,
  output logic [kvt_pkg::VAL_W-1:0]    val_wdata_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output kvt_pkg::result_t             res_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  kvt_pkg::state_e state_q, state_d;

  logic [kvt_pkg::CMD_W-1:0] cmd_q;
  logic [kvt_pkg::KEY_W-1:0] key_q;
  logic [kvt_pkg::VAL_W-1:0] value_q;

  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] pend_idx_q;
  logic            pend_q;
  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;
  logic [kvt_pkg::VAL_W-1:0] hit_val_q;
  logic            free_q;
  logic [IdxW-1:0] free_idx_q;
  logic [ENTRIES-1:0] valid_q;

  logic accept;
  logic match;
  logic scanning;
  logic commit;
  logic is_get, is_set, is_remove;

  assign is_get    = (cmd_q == kvt_pkg::CMD_GET);
  assign is_set    = (cmd_q == kvt_pkg::CMD_SET);
  assign is_remove = (cmd_q == kvt_pkg::CMD_REMOVE);

  assign scanning = (state_q == kvt_pkg::ST_SCAN) || (state_q == kvt_pkg::ST_LAST);
  // Read data of pend_idx_q is on the store outputs in this cycle.
  assign match = scanning && pend_q && valid_q[pend_idx_q] && (key_rdata_i == key_q);
  assign accept = req_valid_i && req_ready_o;
  assign commit = (state_q == kvt_pkg::ST_RESP) && res_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kvt_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          state_d = kvt_pkg::ST_SCAN;
        end
      end
      kvt_pkg::ST_SCAN: begin
        if (match) begin
          state_d = kvt_pkg::ST_RESP;
        end else if (idx_q == LastIdx) begin
          state_d = kvt_pkg::ST_LAST;
        end
      end
      kvt_pkg::ST_LAST: begin
        state_d = kvt_pkg::ST_RESP;
      end
      kvt_pkg::ST_RESP: begin
        if (res_ready_i) begin
          state_d = kvt_pkg::ST_IDLE;
        end
      end
      default: state_d = kvt_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    req_ready_o = (state_q == kvt_pkg::ST_IDLE);
    res_valid_o = (state_q == kvt_pkg::ST_RESP);
    raddr_o     = idx_q;
    key_wdata_o = key_q;
    val_wdata_o = value_q;
    key_we_o    = 1'b0;
    val_we_o    = 1'b0;
    waddr_o     = hit_idx_q;
    if (commit && is_set) begin
      if (hit_q) begin
        val_we_o = 1'b1;
      end else if (free_q) begin
        waddr_o  = free_idx_q;
        key_we_o = 1'b1;
        val_we_o = 1'b1;
      end
    end
    res_o.hit   = hit_q && (is_get || is_set || is_remove);
    res_o.value = (is_get && hit_q) ? hit_val_q : '0;
    res_o.full  = is_set && !hit_q && !free_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kvt_pkg::ST_IDLE;
      valid_q <= '0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        idx_q  <= '0;
        pend_q <= 1'b0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end
      if (state_q == kvt_pkg::ST_SCAN) begin
        pend_q <= 1'b1;
        if (idx_q != LastIdx) begin
          idx_q <= idx_q + IdxW'(1);
        end
        // The lowest free entry is found as the scan passes it.
        if (!valid_q[idx_q] && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (match) begin
        hit_q <= 1'b1;
      end
      if (commit) begin
        if (is_set && !hit_q && free_q) begin
          valid_q[free_idx_q] <= 1'b1;
        end
        if (is_remove && hit_q) begin
          valid_q[hit_idx_q] <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= req_cmd_i;
      key_q   <= req_key_i;
      value_q <= req_value_i;
    end
    if (state_q == kvt_pkg::ST_SCAN) begin
      pend_idx_q <= idx_q;
      if (!valid_q[idx_q] && !free_q) begin
        free_idx_q <= idx_q;
      end
    end
    if (match) begin
      hit_idx_q <= pend_idx_q;
      hit_val_q <= val_rdata_i;
    end
  end

endmodule
